// ----- rtl/k_way_key_merge_assert.svh -----
// Assertion macros shared by the merge selector RTL.
`ifndef K_WAY_KEY_MERGE_ASSERT_SVH
`define K_WAY_KEY_MERGE_ASSERT_SVH

// Same-cycle implication, checked on each rising edge outside reset.
`define KWM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on each rising edge outside reset.
`define KWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/kwm_pkg.sv -----
// Types and constants of the k-way key merge selector.
package kwm_pkg;

    localparam int MAX_STREAMS_DEF = 16;
    localparam int KEY_WORDS       = 8;
    localparam int WORD_W          = 64;
    localparam int KEY_W           = KEY_WORDS * WORD_W;
    localparam int IDX_W           = 4;

    typedef enum logic [1:0] {
        OP_LOAD      = 2'd0,
        OP_START     = 2'd1,
        OP_REFILL    = 2'd2,
        OP_EXHAUSTED = 2'd3
    } t_op;

    // Broadcast from the top level to every cell
    typedef struct packed {
        logic                  accept;
        t_op                   op;
        logic [IDX_W-1:0]      idx;
        logic [IDX_W-1:0]      last;
        logic                  winner_live;
        logic [KEY_W-1:0]      key;
    } t_cell_ctl;

    // Running best handed from cell to cell
    typedef struct packed {
        logic                  vld;
        logic                  found;
        logic [IDX_W-1:0]      idx;
        logic [KEY_W-1:0]      key;
    } t_tok;

endpackage

// ----- rtl/kwm_cell.sv -----
// One stream cell: holds a head key and live flag, compares against the passing best.
module kwm_cell #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kwm_pkg::t_cell_ctl i_ctl,
    input  kwm_pkg::t_tok      i_tok,
    output kwm_pkg::t_tok      o_tok,
    output logic               o_hit
);

    localparam int IW       = kwm_pkg::IDX_W;
    localparam bit IN_RANGE = (IDX < (1 << IW));

    logic                      r_live;
    logic [kwm_pkg::KEY_W-1:0] r_key;
    kwm_pkg::t_tok             r_out;
    kwm_pkg::t_tok             n_out;
    logic                      match_last;
    logic                      do_load;
    logic                      do_refill;
    logic                      do_retire;
    logic                      take;

    // Decode writes aimed at this stream
    assign match_last = IN_RANGE && (i_ctl.last == IW'(IDX));
    assign do_load    = i_ctl.accept && (i_ctl.op == kwm_pkg::OP_LOAD)
                        && IN_RANGE && (i_ctl.idx == IW'(IDX));
    assign do_refill  = i_ctl.accept && (i_ctl.op == kwm_pkg::OP_REFILL)
                        && i_ctl.winner_live && match_last;
    assign do_retire  = i_ctl.accept && (i_ctl.op == kwm_pkg::OP_EXHAUSTED)
                        && i_ctl.winner_live && match_last;
    assign o_hit      = match_last && r_live;

    // Hold live flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else if (do_load) begin
            r_live <= 1'b1;
        end else if (do_retire) begin
            r_live <= 1'b0;
        end
    end

    // Hold head key
    always_ff @(posedge i_clk) begin
        if (do_load || do_refill) begin
            r_key <= i_ctl.key;
        end
    end

    // Replace the best only on a strictly smaller key, so ties keep the lower index
    assign take = i_tok.vld && r_live && (!i_tok.found || (r_key < i_tok.key));

    always_comb begin
        n_out = i_tok;
        if (take) begin
            n_out.found = 1'b1;
            n_out.idx   = IW'(IDX);
            n_out.key   = r_key;
        end
    end

    // Advance the best to the neighbour
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.vld <= 1'b0;
        end else begin
            r_out <= n_out;
        end
    end

    assign o_tok = r_out;

endmodule

// ----- rtl/k_way_key_merge.sv -----
// Top level of the k-way key merge selector: handshakes and the row of stream cells.
//
// Input channel (i_in_valid / o_in_stall) carries one request: a head key load, a
// merge start, a refill of the winner's key or the winner's retirement. Output
// channel (o_out_valid / i_out_stall) returns one winner per start, refill or
// retirement; a load returns nothing.
// Keys live in a row of MAX_STREAMS cells, one stream each. A selection sends a
// running best down the row, one cell per cycle, each cell holding one 512-bit
// comparator. A selecting request is registered into a launch flag, then passes
// each cell's register to the result register; a load is written on acceptance.
// One request is in work at a time: o_in_stall stays high from the acceptance of a
// selecting request until its result has been taken, so no new request is taken
// while a selection is in work or its result waits.
// While the receiver stalls, the result register holds winner and all_done.
// Reset clears all live flags, the last winner and both handshakes; head keys are
// left unset and are only ever read after a load has written them.
// all_done = 1 with winner 0 means no live stream remains.
`include "k_way_key_merge_assert.svh"

module k_way_key_merge #(
    parameter int MAX_STREAMS = kwm_pkg::MAX_STREAMS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_op,
    input  logic [kwm_pkg::IDX_W-1:0]    i_stream_index,
    input  logic [kwm_pkg::WORD_W-1:0]   i_key_word_0,
    input  logic [kwm_pkg::WORD_W-1:0]   i_key_word_1,
    input  logic [kwm_pkg::WORD_W-1:0]   i_key_word_2,
    input  logic [kwm_pkg::WORD_W-1:0]   i_key_word_3,
    input  logic [kwm_pkg::WORD_W-1:0]   i_key_word_4,
    input  logic [kwm_pkg::WORD_W-1:0]   i_key_word_5,
    input  logic [kwm_pkg::WORD_W-1:0]   i_key_word_6,
    input  logic [kwm_pkg::WORD_W-1:0]   i_key_word_7,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [kwm_pkg::IDX_W-1:0]    o_winner,
    output logic                         o_all_done
);

    logic                         in_acc;
    logic                         out_acc;
    kwm_pkg::t_op                 op;
    kwm_pkg::t_cell_ctl           ctl;
    kwm_pkg::t_tok                inject;
    kwm_pkg::t_tok                tok [MAX_STREAMS];
    logic [MAX_STREAMS-1:0]       hit;
    logic                         r_busy;
    logic                         r_launch;
    logic                         r_out_valid;
    logic [kwm_pkg::IDX_W-1:0]    r_winner;
    logic                         r_all_done;
    logic [kwm_pkg::IDX_W-1:0]    r_last_winner;
    kwm_pkg::t_tok                tail;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = r_out_valid && !i_out_stall;
    assign op      = kwm_pkg::t_op'(i_op);

    // Broadcast the request to the cells
    always_comb begin
        ctl.accept      = in_acc;
        ctl.op          = op;
        ctl.idx         = i_stream_index;
        ctl.last        = r_last_winner;
        ctl.winner_live = |hit;
        ctl.key         = {i_key_word_0, i_key_word_1, i_key_word_2, i_key_word_3,
                           i_key_word_4, i_key_word_5, i_key_word_6, i_key_word_7};
    end

    // Start the sweep with no best yet
    always_comb begin
        inject       = '0;
        inject.vld   = r_launch;
    end

    for (genvar g = 0; g < MAX_STREAMS; g++) begin : g_cell
        kwm_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_tok   ((g == 0) ? inject : tok[(g == 0) ? 0 : g - 1]),
            .o_tok   (tok[g]),
            .o_hit   (hit[g])
        );
    end

    assign tail = tok[MAX_STREAMS-1];

    // Hold off new requests while a selection is in work or its result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_launch <= 1'b0;
        end else begin
            r_launch <= in_acc && (op != kwm_pkg::OP_LOAD);
            if (in_acc && (op != kwm_pkg::OP_LOAD)) begin
                r_busy <= 1'b1;
            end else if (out_acc) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Capture the result at the end of the row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_last_winner <= '0;
        end else begin
            if (tail.vld) begin
                r_out_valid <= 1'b1;
                if (tail.found) begin
                    r_last_winner <= tail.idx;
                end
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail.vld) begin
            r_winner   <= tail.found ? tail.idx : '0;
            r_all_done <= !tail.found;
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_winner    = r_winner;
    assign o_all_done  = r_all_done;

    `KWM_ASSERT_NEXT(a_launch_after_select, in_acc && (op != kwm_pkg::OP_LOAD), r_launch && r_busy, "selecting request did not launch a sweep")
    `KWM_ASSERT_NOW(a_launch_busy, r_launch, r_busy && !r_out_valid, "sweep launched while idle or result pending")
    `KWM_ASSERT_NOW(a_tail_busy, tail.vld, r_busy && !r_out_valid, "sweep finished with no request in work")
    `KWM_ASSERT_NOW(a_done_winner_zero, r_out_valid && r_all_done, r_winner == '0, "all_done result carries a nonzero winner")

endmodule
